>>> hw/rtl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// Widths and types shared by the point light diffuse shading pipeline.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int unsigned CH         = 3;
  localparam int unsigned COORD_W    = 21;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned DIFF_W     = 22;
  localparam int unsigned SQ_W       = 43;
  localparam int unsigned SUMSQ_W    = 44;
  localparam int unsigned ND_W       = 38;
  localparam int unsigned DOT_W      = 39;
  localparam int unsigned PROJ_W     = 38;
  localparam int unsigned ROOT_W     = 30;
  localparam int unsigned COS_SHIFT  = 24;
  localparam int unsigned COS_W      = 32;
  localparam int unsigned RAD_W      = 21;
  localparam int unsigned PROD_W     = COS_W + RAD_W;
  localparam int unsigned DEN_SHIFT  = 4;
  localparam int unsigned DEN_W      = SUMSQ_W + DEN_SHIFT;
  localparam int unsigned SQRT_SHIFT = 16;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned ACC_W      = OUT_W + 2;
  localparam int unsigned REG_W      = 63;
  localparam int unsigned REG_COUNT  = 8;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned BANK_SIZE  = 4;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned NORM_BASE  = CH * COORD_W;

  typedef struct packed {
    logic lit;
    logic zero;
    logic cos_ovf;
  } lane_flags_t;

endpackage

>>> hw/rtl/point_light_diffuse_shade.sv
// ----------------------------------------------------------------------------
// point_light_diffuse_shade
// Lambert diffuse light from a bank of point lights with inverse square
// falloff, summed per color channel with saturation.
//
// A shading point and its normal arrive as one transfer on the s_axis
// channel. The summed red, green and blue light leave as one transfer on the
// m_axis channel, with the saturation flag in tuser. Light positions and
// radiances must be written through the cfg port only while no item is in
// flight; the block does not check this. One item is accepted per cycle
// unless stalled. Results pass four stages for differences, products and
// sums, thirty for the square root, thirty-two for each of the two dividers,
// one for the color products, and the output register. Items leave in
// input order. Reset clears the light registers and empties the pipeline.
// When the receiver stalls with a result held in the output register, the
// pipeline still moves while its last stage is empty, and freezes otherwise.
// ----------------------------------------------------------------------------
module point_light_diffuse_shade #(
  parameter int unsigned NUM_LIGHTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, zero pad
  input  logic [pld_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // red_sum, green_sum, blue_sum
  output logic [pld_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // saturated
  output logic                            m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [pld_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pld_pkg::REG_W-1:0]       cfg_data_i
);

  import pld_pkg::*;

  localparam int unsigned PIPE_DEPTH = 4 + ROOT_W + COS_W + 1 + COS_W;
  localparam int unsigned SQ_SIDE_W  = SUMSQ_W + PROJ_W + 2;
  localparam int unsigned D1_SIDE_W  = SUMSQ_W + 2;
  localparam int unsigned FLAG_W     = $bits(lane_flags_t);

  logic [REG_W-1:0] cfg_q [REG_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic                  en;
  logic                  last_vld;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  out_vld_q;

  assign last_vld      = vld_q[PIPE_DEPTH-1];
  assign en            = !out_vld_q || m_axis_tready || !last_vld;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  logic [COORD_W-1:0] hit_q  [CH];
  logic [NORM_W-1:0]  nrm_q  [CH];
  logic [NORM_W-1:0]  nrm_b_q[CH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < CH; c++) begin
        hit_q[c]   <= s_axis_tdata[c*COORD_W +: COORD_W];
        nrm_q[c]   <= s_axis_tdata[NORM_BASE + c*NORM_W +: NORM_W];
        nrm_b_q[c] <= nrm_q[c];
      end
    end
  end

  logic [COS_W-1:0]  q2     [NUM_LIGHTS][CH];
  logic              ovf2   [NUM_LIGHTS][CH];
  lane_flags_t       flags2 [NUM_LIGHTS][CH];

  for (genvar l = 0; l < NUM_LIGHTS; l++) begin : g_lane
    logic [REG_W-1:0]         pos;
    logic [REG_W-1:0]         rad;
    logic signed [DIFF_W-1:0] d_q  [CH];
    logic [SQ_W-1:0]          sq_q [CH];
    logic signed [ND_W-1:0]   nd_q [CH];
    logic [SUMSQ_W-1:0]       s_q;
    logic [PROJ_W-1:0]        p_q;
    logic                     lit_q;
    logic                     zero_q;
    logic [SUMSQ_W-1:0]       s_sum;
    logic signed [DOT_W-1:0]  dot_sum;
    logic [DOT_W-1:0]         neg_dot;
    logic [ROOT_W-1:0]        root;
    logic [SQ_SIDE_W-1:0]     sq_side;
    logic [COS_W-1:0]         cq;
    logic                     cq_ovf;
    logic [D1_SIDE_W-1:0]     d1_side;
    logic [PROD_W-1:0]        prod_q [CH];
    logic [DEN_W-1:0]         den_q;
    lane_flags_t              flags_q;

    assign pos = cfg_q[2*l];
    assign rad = cfg_q[2*l+1];

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < CH; c++) begin
          d_q[c] <= $signed({hit_q[c][COORD_W-1], hit_q[c]})
                  - $signed({pos[c*COORD_W+COORD_W-1], pos[c*COORD_W +: COORD_W]});
        end
      end
    end

    for (genvar c = 0; c < CH; c++) begin : g_mul
      logic signed [2*DIFF_W-1:0] sq_full;
      logic signed [ND_W-1:0]     nd_full;
      assign sq_full = d_q[c] * d_q[c];
      assign nd_full = $signed(nrm_b_q[c]) * d_q[c];
      always_ff @(posedge clk_i) begin
        if (en) begin
          sq_q[c] <= sq_full[SQ_W-1:0];
          nd_q[c] <= nd_full;
        end
      end
    end

    assign s_sum   = SUMSQ_W'(sq_q[0]) + SUMSQ_W'(sq_q[1]) + SUMSQ_W'(sq_q[2]);
    assign dot_sum = DOT_W'(nd_q[0]) + DOT_W'(nd_q[1]) + DOT_W'(nd_q[2]);
    assign neg_dot = -dot_sum;

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_q    <= s_sum;
        p_q    <= neg_dot[PROJ_W-1:0];
        zero_q <= s_sum == '0;
        lit_q  <= (s_sum != '0) && dot_sum[DOT_W-1];
      end
    end

    pld_isqrt #(
      .R_W   (ROOT_W),
      .SIDE_W(SQ_SIDE_W)
    ) u_isqrt (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   ({s_q, {SQRT_SHIFT{1'b0}}}),
      .side_i({s_q, p_q, lit_q, zero_q}),
      .root_o(root),
      .side_o(sq_side)
    );

    pld_div #(
      .N_W   (PROJ_W + COS_SHIFT),
      .D_W   (ROOT_W),
      .Q_W   (COS_W),
      .SIDE_W(D1_SIDE_W)
    ) u_cos_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({sq_side[2 +: PROJ_W], {COS_SHIFT{1'b0}}}),
      .den_i (root),
      .side_i({sq_side[SQ_SIDE_W-1 -: SUMSQ_W], sq_side[1:0]}),
      .quo_o (cq),
      .ovf_o (cq_ovf),
      .side_o(d1_side)
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < CH; c++) begin
          prod_q[c] <= cq * rad[c*RAD_W +: RAD_W];
        end
        den_q           <= {d1_side[D1_SIDE_W-1:2], {DEN_SHIFT{1'b0}}};
        flags_q.lit     <= d1_side[1];
        flags_q.zero    <= d1_side[0];
        flags_q.cos_ovf <= cq_ovf;
      end
    end

    for (genvar c = 0; c < CH; c++) begin : g_chan
      pld_div #(
        .N_W   (PROD_W),
        .D_W   (DEN_W),
        .Q_W   (COS_W),
        .SIDE_W(FLAG_W)
      ) u_light_div (
        .clk_i (clk_i),
        .en_i  (en),
        .num_i (prod_q[c]),
        .den_i (den_q),
        .side_i(flags_q),
        .quo_o (q2[l][c]),
        .ovf_o (ovf2[l][c]),
        .side_o(flags2[l][c])
      );
    end
  end

  logic [OUT_W-1:0] res [CH];
  logic             res_sat;

  always_comb begin
    logic [ACC_W-1:0] acc;
    logic             sat_c;
    logic             zero_any;
    zero_any = 1'b0;
    for (int l = 0; l < NUM_LIGHTS; l++) begin
      zero_any = zero_any | flags2[l][0].zero;
    end
    res_sat = zero_any;
    for (int c = 0; c < CH; c++) begin
      acc   = '0;
      sat_c = zero_any;
      for (int l = 0; l < NUM_LIGHTS; l++) begin
        if (flags2[l][0].lit) begin
          acc   = acc + ACC_W'(q2[l][c]);
          sat_c = sat_c | ovf2[l][c] | flags2[l][0].cos_ovf;
        end
      end
      if (acc[ACC_W-1:OUT_W] != '0) begin
        sat_c = 1'b1;
      end
      res[c]  = sat_c ? {OUT_W{1'b1}} : acc[OUT_W-1:0];
      res_sat = res_sat | sat_c;
    end
  end

  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en && last_vld) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_vld) begin
      out_data_q <= {res[2], res[1], res[0]};
      out_sat_q  <= res_sat;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("Input stalled while the output register is empty.");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(last_vld))
    else $error("Result appeared without a valid item in the last stage.");

  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && m_axis_tready && last_vld |=> out_vld_q)
    else $error("Output register failed to take the next result.");

endmodule

>>> hw/rtl/pld_isqrt.sv
// ----------------------------------------------------------------------------
// pld_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module pld_isqrt #(
  parameter int unsigned R_W    = 30,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*R_W-1:0]    x_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic [R_W-1:0]      root_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic [R_W+1:0]    rem_q  [R_W];
  logic [R_W-1:0]    root_q [R_W];
  logic [2*R_W-1:0]  xs_q   [R_W];
  logic [SIDE_W-1:0] side_q [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [R_W+1:0]    rem_in;
    logic [R_W-1:0]    root_in;
    logic [2*R_W-1:0]  xs_in;
    logic [SIDE_W-1:0] side_in;
    logic [R_W+3:0]    trial;
    logic [R_W+3:0]    cand;
    logic [R_W+3:0]    diff;
    logic              ge;

    if (k == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = x_i;
      assign side_in = side_i;
    end else begin : g_body
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign xs_in   = xs_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, xs_in[2*R_W-1 -: 2]};
    assign cand  = {2'b00, root_in, 2'b01};
    assign ge    = trial >= cand;
    assign diff  = trial - cand;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[R_W+1:0] : trial[R_W+1:0];
        root_q[k] <= {root_in[R_W-2:0], ge};
        xs_q[k]   <= xs_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o = root_q[R_W-1];
  assign side_o = side_q[R_W-1];

endmodule

>>> hw/rtl/pld_div.sv
// ----------------------------------------------------------------------------
// pld_div
// Pipelined restoring divider, one quotient bit per register stage, with a
// flag for quotients that do not fit in the quotient width.
// ----------------------------------------------------------------------------
module pld_div #(
  parameter int unsigned N_W    = 62,
  parameter int unsigned D_W    = 30,
  parameter int unsigned Q_W    = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [N_W-1:0]    num_i,
  input  logic [D_W-1:0]    den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [Q_W-1:0]    quo_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned IW = N_W - Q_W;
  localparam int unsigned CW = (IW > D_W) ? IW : D_W;

  logic [CW-1:0] init_ext;
  logic [CW-1:0] den_ext;
  logic          ovf_head;

  assign init_ext = CW'(num_i[N_W-1:Q_W]);
  assign den_ext  = CW'(den_i);
  assign ovf_head = init_ext >= den_ext;

  logic [D_W-1:0]    rem_q  [Q_W];
  logic [Q_W-1:0]    low_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [D_W-1:0]    den_q  [Q_W];
  logic              ovf_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W-1:0]    rem_in;
    logic [Q_W-1:0]    low_in;
    logic [Q_W-1:0]    quo_in;
    logic [D_W-1:0]    den_in;
    logic              ovf_in;
    logic [SIDE_W-1:0] side_in;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              ge;

    if (k == 0) begin : g_head
      assign rem_in  = init_ext[D_W-1:0];
      assign low_in  = num_i[Q_W-1:0];
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign ovf_in  = ovf_head;
      assign side_in = side_i;
    end else begin : g_body
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign ovf_in  = ovf_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, low_in[Q_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        low_q[k]  <= low_in << 1;
        quo_q[k]  <= {quo_in[Q_W-2:0], ge};
        den_q[k]  <= den_in;
        ovf_q[k]  <= ovf_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign quo_o  = quo_q[Q_W-1];
  assign ovf_o  = ovf_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule
